// ===== sv/skf_pkg.sv =====
// Shared types and constants for the dual scalar Kalman range filter.
// Fixed-point widths, the sequencer state type and register indexes.
// No dependencies; used by skf_div and dual_scalar_kalman_range_filter.
`default_nettype none

package skf_pkg;

   // Fixed-point layout
   localparam int FRAC_BITS = 16;
   localparam int DIST_W    = 14;
   localparam int EST_W     = DIST_W + FRAC_BITS;
   localparam int OUT_W     = 30;
   localparam int NOISE_W   = 24;
   localparam int GAIN_FRAC = 24;
   localparam int VAR_W     = GAIN_FRAC + 1;
   localparam int GAIN_W    = GAIN_FRAC + 1;
   localparam int SUM_W     = VAR_W + 1;
   localparam int NUM_W     = VAR_W + GAIN_FRAC + 1;
   localparam int MUL_B_W   = (EST_W > GAIN_W) ? EST_W : GAIN_W;
   localparam int PROD_W    = GAIN_W + MUL_B_W;

   // Serial divider
   localparam int DIV_STEPS = GAIN_W;
   localparam int CNT_W     = $clog2(DIV_STEPS + 1);

   // Stream and register port widths
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 64;
   localparam int RSP_PAD_W  = RSP_DATA_W - 2 * OUT_W - 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = NOISE_W;

   // Constants in fixed point
   localparam logic [GAIN_W-1:0] GAIN_ONE   = GAIN_W'(1) << GAIN_FRAC;
   localparam logic [VAR_W-1:0]  VAR_MAX    = {VAR_W{1'b1}};
   localparam logic [VAR_W-1:0]  VAR_RESET  = VAR_W'(1) << GAIN_FRAC;
   localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (GAIN_FRAC - 1);

   // Register reset values
   localparam logic [NOISE_W-1:0] PROCESS_NOISE_RESET     = NOISE_W'(16777);
   localparam logic [NOISE_W-1:0] MEASUREMENT_NOISE_RESET = NOISE_W'(503316);
   localparam logic [DIST_W-1:0]  NEAR_THRESHOLD_RESET    = DIST_W'(50);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PROCESS_NOISE     = 2'd0,
      CSR_MEASUREMENT_NOISE = 2'd1,
      CSR_NEAR_THRESHOLD    = 2'd2
   } csr_index_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_PRED,
      S_DIV_GO,
      S_DIV_WAIT,
      S_MUL_EST,
      S_UPD_EST,
      S_MUL_VAR,
      S_UPD_VAR,
      S_OUT
   } state_type;

   // Divider result toward the sequencer
   typedef struct packed {
      logic              done;
      logic [GAIN_W-1:0] quot;
   } div_rsp_type;

endpackage

`default_nettype wire

// ===== sv/skf_div.sv =====
// Serial restoring divider for the Kalman gain, one quotient bit per cycle.
// Forms round(p * 2^24 / s) from variance p and innovation variance s.
// Depends on skf_pkg.
`default_nettype none

module skf_div (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [skf_pkg::VAR_W-1:0]  p,
   input  wire logic [skf_pkg::SUM_W-1:0]  s,
   output skf_pkg::div_rsp_type            rsp
);

   logic [skf_pkg::SUM_W-1:0]  rem_ff;
   logic [skf_pkg::SUM_W-1:0]  den_ff;
   logic [skf_pkg::GAIN_W-1:0] num_ff;
   logic [skf_pkg::GAIN_W-1:0] quot_ff;
   logic [skf_pkg::CNT_W-1:0]  cnt_ff;
   logic                       busy_ff;
   logic                       done_ff;

   logic [skf_pkg::NUM_W-1:0]  numer;
   logic [skf_pkg::SUM_W:0]    trial;
   logic                       fits;

   // Rounded numerator: p shifted up plus half the divisor
   assign numer = skf_pkg::NUM_W'({p, {skf_pkg::GAIN_FRAC{1'b0}}})
                + skf_pkg::NUM_W'(s[skf_pkg::SUM_W-1:1]);

   // Shift in the next numerator bit and try the subtract
   assign trial = {rem_ff, num_ff[skf_pkg::GAIN_W-1]};
   assign fits  = (trial >= {1'b0, den_ff});

   // Control: run for one step per quotient bit, pulse done at the end
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + skf_pkg::CNT_W'(1);
            if (cnt_ff == skf_pkg::CNT_W'(skf_pkg::DIV_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath: load the upper numerator bits, then shift and subtract
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= skf_pkg::SUM_W'(numer[skf_pkg::NUM_W-1:skf_pkg::GAIN_W]);
         num_ff  <= numer[skf_pkg::GAIN_W-1:0];
         den_ff  <= s;
         quot_ff <= '0;
      end else if (busy_ff) begin
         rem_ff  <= fits ? skf_pkg::SUM_W'(trial - {1'b0, den_ff})
                         : skf_pkg::SUM_W'(trial);
         num_ff  <= {num_ff[skf_pkg::GAIN_W-2:0], 1'b0};
         quot_ff <= {quot_ff[skf_pkg::GAIN_W-2:0], fits};
      end
   end

   assign rsp.done = done_ff;
   assign rsp.quot = quot_ff;

endmodule

`default_nettype wire

// ===== sv/dual_scalar_kalman_range_filter.sv =====
// Dual scalar Kalman range filter: left and right sonar ranges, one filter each.
//
// Channels: req_* takes one transfer holding both raw readings; rsp_* returns
// one transfer holding both filtered distances (UQ14.16) and a near flag per
// side. csr_* writes a register: index 0 process noise q, 1 measurement noise
// r (both UQ0.24), 2 near threshold in distance units. csr_ready is always
// high; write registers only while no reading is in flight.
// Sequence: req_tready stays low from accept until the sequencer is back in
// idle, so a new reading is accepted only after the last one is through.
// Each side in turn: predict, a 25-step serial gain divide, and two passes
// through the one shared 25x30 multiplier (estimate correction, then
// variance scaling), left side first.
// The next reading is accepted while a result still waits in the output
// register; if that result is still not taken when the next one is ready,
// the sequencer holds in its output state until rsp_tready.
// Reset (synchronous, active high): estimates go to 0, variances to 1.0,
// registers to q = 0.001, r = 0.03, threshold = 50, no result pending.
// Depends on skf_pkg and skf_div.
`default_nettype none

module dual_scalar_kalman_range_filter (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // [13:0] left_distance, [27:14] right_distance, [31:28] zero
   input  wire logic [skf_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  wire logic                             req_tvalid,
   output      logic                             req_tready,
   // [29:0] left_filtered, [59:30] right_filtered, [60] left_near,
   // [61] right_near, [63:62] zero
   output      logic [skf_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output      logic                             rsp_tvalid,
   input  wire logic                             rsp_tready,
   input  wire logic                             csr_valid,
   output      logic                             csr_ready,
   input  wire logic [skf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [skf_pkg::CSR_DATA_W-1:0]   csr_data
);

   skf_pkg::state_type state_ff, state_in;

   logic                         ch_ff;
   logic [skf_pkg::DIST_W-1:0]   left_z_ff, right_z_ff;
   logic [skf_pkg::NOISE_W-1:0]  q_ff, r_ff;
   logic [skf_pkg::DIST_W-1:0]   thr_ff;
   logic [skf_pkg::EST_W-1:0]    left_est_ff, right_est_ff;
   logic [skf_pkg::VAR_W-1:0]    left_var_ff, right_var_ff;
   logic [skf_pkg::VAR_W-1:0]    p_ff;
   logic                         s_zero_ff;
   logic [skf_pkg::EST_W-1:0]    mag_ff;
   logic                         neg_ff;
   logic [skf_pkg::GAIN_W-1:0]   g_ff;
   logic [skf_pkg::PROD_W-1:0]   prod_ff;
   logic                         rsp_valid_ff;
   logic [skf_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   logic                         accept;
   logic                         rsp_load;
   logic                         div_start;
   skf_pkg::div_rsp_type         div_rsp;

   logic [skf_pkg::EST_W-1:0]    cur_est;
   logic [skf_pkg::VAR_W-1:0]    cur_var;
   logic [skf_pkg::EST_W-1:0]    z_fix;
   logic [skf_pkg::SUM_W-1:0]    p_sum;
   logic [skf_pkg::VAR_W-1:0]    p_sat;
   logic [skf_pkg::SUM_W-1:0]    s_sum;
   logic [skf_pkg::GAIN_W-1:0]   mul_a;
   logic [skf_pkg::MUL_B_W-1:0]  mul_b;
   logic [skf_pkg::PROD_W-1:0]   prod_rnd;
   logic [skf_pkg::EST_W-1:0]    delta;
   logic [skf_pkg::EST_W-1:0]    est_new;
   logic [skf_pkg::VAR_W-1:0]    var_new;
   logic [skf_pkg::EST_W-1:0]    limit;
   logic                         left_near, right_near;

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == skf_pkg::S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Select the channel being worked on
   assign cur_est = ch_ff ? right_est_ff : left_est_ff;
   assign cur_var = ch_ff ? right_var_ff : left_var_ff;
   assign z_fix   = {ch_ff ? right_z_ff : left_z_ff, {skf_pkg::FRAC_BITS{1'b0}}};

   // Predict: add q and saturate; innovation variance adds r
   assign p_sum = skf_pkg::SUM_W'(cur_var) + skf_pkg::SUM_W'(q_ff);
   assign p_sat = (p_sum > skf_pkg::SUM_W'(skf_pkg::VAR_MAX)) ? skf_pkg::VAR_MAX
                                                             : p_sum[skf_pkg::VAR_W-1:0];
   assign s_sum = skf_pkg::SUM_W'(p_ff) + skf_pkg::SUM_W'(r_ff);

   // Shared multiplier operands: gain times residual, then variance times 1-g
   always_comb begin
      if (state_ff == skf_pkg::S_MUL_VAR) begin
         mul_a = p_ff;
         mul_b = skf_pkg::MUL_B_W'(skf_pkg::GAIN_ONE - g_ff);
      end else begin
         mul_a = g_ff;
         mul_b = skf_pkg::MUL_B_W'(mag_ff);
      end
   end

   // Round half up and drop the gain fraction
   assign prod_rnd = prod_ff + skf_pkg::ROUND_HALF;
   assign delta    = skf_pkg::EST_W'(prod_rnd[skf_pkg::PROD_W-1:skf_pkg::GAIN_FRAC]);
   assign var_new  = skf_pkg::VAR_W'(prod_rnd[skf_pkg::PROD_W-1:skf_pkg::GAIN_FRAC]);
   assign est_new  = neg_ff ? (cur_est - delta) : (cur_est + delta);

   // Near flags against the threshold in estimate format
   assign limit      = {thr_ff, {skf_pkg::FRAC_BITS{1'b0}}};
   assign left_near  = (left_est_ff < limit);
   assign right_near = (right_est_ff < limit);

   skf_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .p     (p_ff),
      .s     (s_sum),
      .rsp   (div_rsp)
   );

   // Sequencer state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= skf_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and strobes
   always_comb begin
      state_in  = state_ff;
      div_start = 1'b0;
      rsp_load  = 1'b0;
      case (state_ff)
         skf_pkg::S_IDLE: begin
            if (accept) begin
               state_in = skf_pkg::S_PRED;
            end
         end
         skf_pkg::S_PRED: begin
            state_in = skf_pkg::S_DIV_GO;
         end
         skf_pkg::S_DIV_GO: begin
            div_start = 1'b1;
            state_in  = skf_pkg::S_DIV_WAIT;
         end
         skf_pkg::S_DIV_WAIT: begin
            if (div_rsp.done) begin
               state_in = skf_pkg::S_MUL_EST;
            end
         end
         skf_pkg::S_MUL_EST: begin
            state_in = skf_pkg::S_UPD_EST;
         end
         skf_pkg::S_UPD_EST: begin
            state_in = skf_pkg::S_MUL_VAR;
         end
         skf_pkg::S_MUL_VAR: begin
            state_in = skf_pkg::S_UPD_VAR;
         end
         skf_pkg::S_UPD_VAR: begin
            state_in = ch_ff ? skf_pkg::S_OUT : skf_pkg::S_PRED;
         end
         skf_pkg::S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = skf_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = skf_pkg::S_IDLE;
         end
      endcase
   end

   // Configuration registers and filter state
   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff         <= skf_pkg::PROCESS_NOISE_RESET;
         r_ff         <= skf_pkg::MEASUREMENT_NOISE_RESET;
         thr_ff       <= skf_pkg::NEAR_THRESHOLD_RESET;
         left_est_ff  <= '0;
         right_est_ff <= '0;
         left_var_ff  <= skf_pkg::VAR_RESET;
         right_var_ff <= skf_pkg::VAR_RESET;
         ch_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (skf_pkg::csr_index_type'(csr_index))
               skf_pkg::CSR_PROCESS_NOISE:     q_ff   <= csr_data;
               skf_pkg::CSR_MEASUREMENT_NOISE: r_ff   <= csr_data;
               skf_pkg::CSR_NEAR_THRESHOLD:    thr_ff <= csr_data[skf_pkg::DIST_W-1:0];
               default: ;
            endcase
         end
         if (accept) begin
            ch_ff <= 1'b0;
         end else if (state_ff == skf_pkg::S_UPD_VAR) begin
            ch_ff <= ~ch_ff;
         end
         // Write back the corrected estimate and scaled variance
         if (state_ff == skf_pkg::S_UPD_EST) begin
            if (ch_ff) begin
               right_est_ff <= est_new;
            end else begin
               left_est_ff <= est_new;
            end
         end
         if (state_ff == skf_pkg::S_UPD_VAR) begin
            if (ch_ff) begin
               right_var_ff <= var_new;
            end else begin
               left_var_ff <= var_new;
            end
         end
         // Hold the result until the receiver takes the transfer
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Working registers of the current channel
   always_ff @(posedge clock) begin
      if (accept) begin
         left_z_ff  <= req_tdata[skf_pkg::DIST_W-1:0];
         right_z_ff <= req_tdata[2*skf_pkg::DIST_W-1:skf_pkg::DIST_W];
      end
      if (state_ff == skf_pkg::S_PRED) begin
         p_ff   <= p_sat;
         neg_ff <= (z_fix < cur_est);
         mag_ff <= (z_fix < cur_est) ? (cur_est - z_fix) : (z_fix - cur_est);
      end
      if (state_ff == skf_pkg::S_DIV_GO) begin
         s_zero_ff <= (s_sum == '0);
      end
      // Clamp the gain to one; zero denominator gives zero gain
      if ((state_ff == skf_pkg::S_DIV_WAIT) && div_rsp.done) begin
         if (s_zero_ff) begin
            g_ff <= '0;
         end else if (div_rsp.quot > skf_pkg::GAIN_ONE) begin
            g_ff <= skf_pkg::GAIN_ONE;
         end else begin
            g_ff <= div_rsp.quot;
         end
      end
      if ((state_ff == skf_pkg::S_MUL_EST) || (state_ff == skf_pkg::S_MUL_VAR)) begin
         prod_ff <= skf_pkg::PROD_W'(mul_a) * skf_pkg::PROD_W'(mul_b);
      end
      if (rsp_load) begin
         rsp_data_ff <= {{skf_pkg::RSP_PAD_W{1'b0}}, right_near, left_near,
                         skf_pkg::OUT_W'(right_est_ff), skf_pkg::OUT_W'(left_est_ff)};
      end
   end

   // The estimate moves toward the reading and never passes it
   a_est_between: assert property (@(posedge clock) disable iff (reset)
      (state_ff == skf_pkg::S_UPD_EST) |->
         (neg_ff ? (est_new <= cur_est && est_new >= z_fix)
                 : (est_new >= cur_est && est_new <= z_fix)))
      else $error("estimate update overshoots the reading");

   // The gain used for correction is at most one
   a_gain_le_one: assert property (@(posedge clock) disable iff (reset)
      (state_ff == skf_pkg::S_MUL_EST) |-> (g_ff <= skf_pkg::GAIN_ONE))
      else $error("gain above one");

   // Variance scaling by 1-g never grows the variance
   a_var_shrinks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == skf_pkg::S_UPD_VAR) |-> (var_new <= p_ff))
      else $error("variance grew in update");

   // Divider finishes only while the sequencer waits on it
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == skf_pkg::S_DIV_WAIT))
      else $error("divider done outside wait state");

   // An accepted reading starts with the left channel
   a_start_left: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == skf_pkg::S_PRED && !ch_ff))
      else $error("reading did not start on the left channel");

endmodule

`default_nettype wire

// ===== test/range_filter_check.sv =====
// Result checker for the dual scalar Kalman range filter testbench.
// Watches the request, result and register channels, predicts each result and compares it.
// Depends on skf_pkg for the fixed-point widths, reset values and register indexes.
`default_nettype none

module range_filter_check (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic [skf_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  wire logic                             req_tvalid,
   input  wire logic                             req_tready,
   input  wire logic [skf_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  wire logic                             rsp_tvalid,
   input  wire logic                             rsp_tready,
   input  wire logic                             csr_valid,
   input  wire logic                             csr_ready,
   input  wire logic [skf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [skf_pkg::CSR_DATA_W-1:0]   csr_data,
   output int                                    pending_results,
   output int                                    mismatch_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DIST_W    = skf_pkg::DIST_W;
   localparam int EST_W     = skf_pkg::EST_W;
   localparam int VAR_W     = skf_pkg::VAR_W;
   localparam int OUT_W     = skf_pkg::OUT_W;
   localparam int NOISE_W   = skf_pkg::NOISE_W;
   localparam int FRAC_BITS = skf_pkg::FRAC_BITS;
   localparam int GAIN_FRAC = skf_pkg::GAIN_FRAC;

   localparam logic [63:0] UNITY_GAIN = 64'd1 << GAIN_FRAC;
   localparam logic [63:0] VAR_CAP    = (64'd1 << VAR_W) - 64'd1;
   localparam logic [63:0] HALF_LSB   = 64'd1 << (GAIN_FRAC - 1);

   // One side's filter state
   typedef struct packed {
      logic [EST_W-1:0] estimate;
      logic [VAR_W-1:0] variance;
   } side_state_type;

   // Result transfer, lowest field last
   typedef struct packed {
      logic [1:0]       pad;
      logic             right_near;
      logic             left_near;
      logic [OUT_W-1:0] right_filtered;
      logic [OUT_W-1:0] left_filtered;
   } range_result_type;

   logic [NOISE_W-1:0] process_noise;
   logic [NOISE_W-1:0] measurement_noise;
   logic [DIST_W-1:0]  near_threshold;
   side_state_type     left_side;
   side_state_type     right_side;
   range_result_type   expected_results[$];

   initial mismatch_count = 0;

   // Print one line per mismatch and count it
   task automatic report_mismatch(input string field, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t ns: %s got 0x%0h, expected 0x%0h", $time, field, got, want);
      mismatch_count++;
   endtask

   // Predict and update, then correct the estimate and shrink the variance
   function automatic side_state_type advance_side(side_state_type side,
                                                   logic [DIST_W-1:0] reading);
      logic [63:0] p;
      logic [63:0] s;
      logic [63:0] g;
      logic [63:0] z;
      logic [63:0] est;
      logic [63:0] mag;
      logic [63:0] delta;
      side_state_type nxt;
      p = 64'(side.variance) + 64'(process_noise);
      if (p > VAR_CAP)
         p = VAR_CAP;
      s = p + 64'(measurement_noise);
      // both variances zero: the gain is taken as zero
      if (s == 64'd0)
         g = 64'd0;
      else
         g = ((p << GAIN_FRAC) + (s >> 1)) / s;
      if (g > UNITY_GAIN)
         g = UNITY_GAIN;
      z = 64'(reading) << FRAC_BITS;
      est = 64'(side.estimate);
      // round the correction half away from zero
      if (z >= est) begin
         mag = z - est;
         delta = (g * mag + HALF_LSB) >> GAIN_FRAC;
         est = est + delta;
      end else begin
         mag = est - z;
         delta = (g * mag + HALF_LSB) >> GAIN_FRAC;
         est = est - delta;
      end
      p = (p * (UNITY_GAIN - g) + HALF_LSB) >> GAIN_FRAC;
      if (p > VAR_CAP)
         p = VAR_CAP;
      nxt.estimate = est[EST_W-1:0];
      nxt.variance = p[VAR_W-1:0];
      return nxt;
   endfunction

   // Track register writes, compare results, predict on every accepted reading
   always @(posedge clock) begin : watch
      range_result_type got;
      range_result_type want;
      logic [63:0]      limit;
      if (reset) begin
         process_noise     = skf_pkg::PROCESS_NOISE_RESET;
         measurement_noise = skf_pkg::MEASUREMENT_NOISE_RESET;
         near_threshold    = skf_pkg::NEAR_THRESHOLD_RESET;
         left_side.estimate  = '0;
         left_side.variance  = skf_pkg::VAR_RESET;
         right_side.estimate = '0;
         right_side.variance = skf_pkg::VAR_RESET;
         expected_results.delete();
         pending_results <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               skf_pkg::CSR_PROCESS_NOISE:     process_noise = csr_data;
               skf_pkg::CSR_MEASUREMENT_NOISE: measurement_noise = csr_data;
               skf_pkg::CSR_NEAR_THRESHOLD:    near_threshold = csr_data[DIST_W-1:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (expected_results.size() == 0) begin
               report_mismatch("result with no reading outstanding", got, 64'd0);
            end else begin
               want = expected_results.pop_front();
               if (got.left_filtered !== want.left_filtered)
                  report_mismatch("left_filtered", 64'(got.left_filtered),
                                  64'(want.left_filtered));
               if (got.right_filtered !== want.right_filtered)
                  report_mismatch("right_filtered", 64'(got.right_filtered),
                                  64'(want.right_filtered));
               if (got.left_near !== want.left_near)
                  report_mismatch("left_near", 64'(got.left_near), 64'(want.left_near));
               if (got.right_near !== want.right_near)
                  report_mismatch("right_near", 64'(got.right_near), 64'(want.right_near));
               if (got.pad !== want.pad)
                  report_mismatch("padding", 64'(got.pad), 64'(want.pad));
            end
         end
         if (req_tvalid && req_tready) begin
            left_side  = advance_side(left_side, req_tdata[DIST_W-1:0]);
            right_side = advance_side(right_side, req_tdata[2*DIST_W-1:DIST_W]);
            limit = 64'(near_threshold) << FRAC_BITS;
            want.pad            = '0;
            want.left_filtered  = OUT_W'(left_side.estimate);
            want.right_filtered = OUT_W'(right_side.estimate);
            want.left_near      = 64'(left_side.estimate) < limit;
            want.right_near     = 64'(right_side.estimate) < limit;
            expected_results.push_back(want);
         end
         pending_results <= expected_results.size();
      end
   end

endmodule

`default_nettype wire

// ===== test/tb_dual_scalar_kalman_range_filter.sv =====
// Testbench top for the dual scalar Kalman range filter: clock, reset, stimulus and verdict.
// Drives directed and random range readings under several register settings and idle patterns.
// Depends on skf_pkg, dual_scalar_kalman_range_filter and range_filter_check.
`default_nettype none

module tb_dual_scalar_kalman_range_filter;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DIST_W  = skf_pkg::DIST_W;
   localparam int NOISE_W = skf_pkg::NOISE_W;
   localparam int CSR_IDX_W  = skf_pkg::CSR_IDX_W;
   localparam int CSR_DATA_W = skf_pkg::CSR_DATA_W;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_INDEX = 2'd3;
   localparam int DIST_TOP          = 9999;
   localparam int SETTINGS_PER_PASS = 4;
   localparam int READINGS_PER_SET  = 96;
   localparam int SETTLE_CYCLES     = 100;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic [skf_pkg::REQ_DATA_W-1:0]  req_tdata = '0;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [skf_pkg::RSP_DATA_W-1:0]  rsp_tdata;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [CSR_IDX_W-1:0]            csr_index = '0;
   logic [CSR_DATA_W-1:0]           csr_data = '0;
   int                              pending_results;
   int                              mismatch_count;
   int                              send_idle_pct = 28;
   int                              recv_idle_pct = 55;
   int                              left_track;
   int                              right_track;

   always #5 clock = ~clock;

   dual_scalar_kalman_range_filter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   range_filter_check filter_watch (
      .clock           (clock),
      .reset           (reset),
      .req_tdata       (req_tdata),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .pending_results (pending_results),
      .mismatch_count  (mismatch_count)
   );

   // Stall the result channel at random
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Hold back at random, then offer one reading until the transfer; valid stays high after
   task automatic send_reading(input logic [DIST_W-1:0] left, input logic [DIST_W-1:0] right);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= skf_pkg::REQ_DATA_W'({right, left});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Stop sending and wait until every outstanding result has been taken
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
   endtask

   // Offer one register write until the transfer; valid stays high after
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // Write all three registers, sometimes junk in the unused threshold bits, optionally poke index 3
   task automatic set_filter(input logic [NOISE_W-1:0] q, input logic [NOISE_W-1:0] r,
                             input logic [DIST_W-1:0] thr, input logic poke_unused);
      write_csr(skf_pkg::CSR_PROCESS_NOISE, q);
      write_csr(skf_pkg::CSR_MEASUREMENT_NOISE, r);
      write_csr(skf_pkg::CSR_NEAR_THRESHOLD,
                {($urandom_range(1) != 0) ? 10'($urandom) : 10'd0, thr});
      if (poke_unused)
         write_csr(CSR_UNUSED_INDEX, CSR_DATA_W'($urandom));
      csr_valid <= 1'b0;
   endtask

   // Drift a target distance, with an occasional jump
   function automatic int step_track(int t);
      int v;
      if ($urandom_range(49) == 0)
         return $urandom_range(DIST_TOP);
      v = t + int'($urandom_range(300)) - 150;
      if (v < 0)
         v = 0;
      if (v > DIST_TOP)
         v = DIST_TOP;
      return v;
   endfunction

   // Mostly a noisy reading of the target, sometimes a wild one
   function automatic logic [DIST_W-1:0] sample_range(int centre);
      int v;
      v = centre + int'($urandom_range(40)) - 20;
      case ($urandom_range(19))
         0, 1, 2: v = $urandom_range((1 << DIST_W) - 1);
         3, 4:    v = $urandom_range(DIST_TOP);
         default: ;
      endcase
      if (v < 0)
         v = 0;
      if (v > (1 << DIST_W) - 1)
         v = (1 << DIST_W) - 1;
      return DIST_W'(v);
   endfunction

   initial begin : stimulus
      logic [NOISE_W-1:0] q;
      logic [NOISE_W-1:0] r;
      logic [DIST_W-1:0]  thr;
      int                 pass;
      int                 setting;
      int                 n;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset registers: field extremes, alternating bit patterns, readings above 9999
      send_reading(14'd0, 14'd0);
      send_reading(14'd9999, 14'd9999);
      send_reading(14'h3FFF, 14'd0);
      send_reading(14'd0, 14'h3FFF);
      send_reading(14'h2AAA, 14'h1555);
      send_reading(14'h1555, 14'h2AAA);

      // Zero noise: unity gain first, then a zero denominator; threshold above 9999
      drain_results();
      set_filter('0, '0, 14'h3FFF, 1'b1);
      send_reading(14'h3FFF, 14'h3FFF);
      send_reading(14'd0, 14'd100);
      send_reading(14'd12345, 14'd1);

      // Largest noise terms, zero threshold
      drain_results();
      set_filter('1, '1, 14'd0, 1'b0);
      send_reading(14'd9999, 14'd0);
      send_reading(14'd1, 14'd9998);
      send_reading(14'd50, 14'd50);

      // Smallest measurement noise, readings across the threshold
      drain_results();
      set_filter('0, 24'd1, 14'd50, 1'b0);
      send_reading(14'd49, 14'd51);
      send_reading(14'd50, 14'd50);
      send_reading(14'd51, 14'd49);
      send_reading(14'd0, 14'd0);

      // Random readings under random settings, three idle patterns
      for (pass = 0; pass < 3; pass++) begin
         case (pass)
            0: begin
               send_idle_pct = 28;
               recv_idle_pct = 55;
            end
            1: begin
               send_idle_pct = 55;
               recv_idle_pct = 28;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         for (setting = 0; setting < SETTINGS_PER_PASS; setting++) begin
            case ($urandom_range(3))
               0:       q = '0;
               1:       q = '1;
               2:       q = NOISE_W'($urandom);
               default: q = NOISE_W'($urandom_range(200000));
            endcase
            case ($urandom_range(4))
               0:       r = '0;
               1:       r = 24'd1;
               2:       r = '1;
               3:       r = NOISE_W'($urandom);
               default: r = NOISE_W'($urandom_range(2000000, 1));
            endcase
            case ($urandom_range(4))
               0:       thr = '0;
               1:       thr = '1;
               2:       thr = DIST_W'($urandom_range(DIST_TOP));
               default: thr = DIST_W'($urandom_range(200));
            endcase
            drain_results();
            set_filter(q, r, thr, $urandom_range(3) == 0);
            left_track  = $urandom_range(DIST_TOP);
            right_track = (thr > DIST_TOP) ? DIST_TOP : int'(thr);
            for (n = 0; n < READINGS_PER_SET; n++) begin
               left_track  = step_track(left_track);
               right_track = step_track(right_track);
               send_reading(sample_range(left_track), sample_range(right_track));
            end
         end
      end

      // Wait for the last results, then watch for strays
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // End a hung run
   initial begin : watchdog
      #(10_000_000);
      $display("Mismatches found");
      $finish;
   end

endmodule

`default_nettype wire

// ===== files.f =====
sv/skf_pkg.sv
sv/skf_div.sv
sv/dual_scalar_kalman_range_filter.sv
test/range_filter_check.sv
test/tb_dual_scalar_kalman_range_filter.sv
